// ===== design/dtrq_pkg.sv =====
// ============================================================================
// dtrq_pkg
// Shared types and constants for the deduplicating transfer request queue.
// ============================================================================
`default_nettype none

package dtrq_pkg;

    // Ring geometry: one slot always stays free
    localparam int QUEUE_SLOTS = 16;
    localparam int IDX_W       = $clog2(QUEUE_SLOTS);
    localparam int CNT_W       = IDX_W;
    localparam int HANDLE_W    = 16;

    // Request kinds
    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_REPLACE = 2'd1,
        MODE_DONE    = 2'd2
    } t_mode;

    // Status reported for a handle
    typedef enum logic [2:0] {
        ST_QUEUED   = 3'd0,
        ST_STARTED  = 3'd1,
        ST_STOPPED  = 3'd2,
        ST_FINISHED = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    // Reply code carried on the final result of a request
    typedef enum logic [1:0] {
        RC_FULL   = 2'd0,
        RC_QUEUED = 2'd1,
        RC_DUP    = 2'd2,
        RC_NONE   = 2'd3
    } t_reply;

    // One result item
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        t_status             status;
        t_reply              reply;
        logic                active;
        logic                last;
    } t_result;

    // Advance a ring index with wrap
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(QUEUE_SLOTS - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + IDX_W'(1);
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== design/dedup_transfer_request_queue_core.sv =====
// ============================================================================
// dedup_transfer_request_queue_core
// Deduplicating ring queue of transfer-request handles with status reporting.
// ============================================================================
// Takes one request at a time (o_stall is high from acceptance until the last
// result of that request has been loaded into the output register). An append
// first runs the duplicate scan, which issues one slot RAM read per cycle from
// the head and compares each returned handle; a match ends the request as a
// duplicate, and a scan with no match refuses the request if the queue is full
// and else appends the handle, which into an empty queue is also reported as
// started. A replace flushes each queued handle (RAM read, then result) and
// then appends. Stalls on the result side hold the sequencer in its emitting
// states. The queue holds up to QUEUE_SLOTS-1 handles.
`default_nettype none

module dedup_transfer_request_queue_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // requests
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [15:0]                   i_handle,
    // results
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [15:0]                   o_report_handle,
    output logic      [2:0]                    o_report_status,
    output logic      [1:0]                    o_reply_code,
    output logic                               o_transfer_active,
    output logic                               o_last
);

    logic                             we;
    logic [dtrq_pkg::IDX_W-1:0]       waddr;
    logic [dtrq_pkg::HANDLE_W-1:0]    wdata;
    logic [dtrq_pkg::IDX_W-1:0]       raddr;
    logic [dtrq_pkg::HANDLE_W-1:0]    rdata;
    logic                             out_ready;
    logic                             push;
    dtrq_pkg::t_result                res;
    dtrq_pkg::t_result                out_res;

    // Slot store
    dtrq_ram #(
        .WIDTH (dtrq_pkg::HANDLE_W),
        .DEPTH (dtrq_pkg::QUEUE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Request sequencer
    dtrq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .i_handle    (i_handle),
        .o_busy      (o_stall),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .i_out_ready (out_ready),
        .o_push      (push),
        .o_res       (res)
    );

    // Result register
    dtrq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_stall (i_stall)
    );

    assign o_report_handle   = out_res.handle;
    assign o_report_status   = out_res.status;
    assign o_reply_code      = out_res.reply;
    assign o_transfer_active = out_res.active;
    assign o_last            = out_res.last;

endmodule

`default_nettype wire

// ===== design/dtrq_ram.sv =====
// ============================================================================
// dtrq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module dtrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/dtrq_out.sv =====
// ============================================================================
// dtrq_out
// Output register stage: holds one result until the receiver takes it.
// ============================================================================
`default_nettype none

module dtrq_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dtrq_pkg::t_result i_res,
    output logic                  o_ready,
    output logic                  o_valid,
    output dtrq_pkg::t_result     o_res,
    input  wire logic             i_stall
);

    logic              r_valid;
    dtrq_pkg::t_result r_res;

    // Free when empty or when the held result leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    // Load a new result, or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== design/dtrq_seq.sv =====
// ============================================================================
// dtrq_seq
// Request sequencer: walks the slot RAM for the duplicate scan and the flush,
// keeps the ring pointers and produces one result at a time.
// ============================================================================
`default_nettype none

module dtrq_seq (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request side
    input  wire logic                             i_valid,
    input  wire logic [1:0]                       i_mode,
    input  wire logic [dtrq_pkg::HANDLE_W-1:0]    i_handle,
    output logic                                  o_busy,
    // slot RAM
    output logic                                  o_we,
    output logic      [dtrq_pkg::IDX_W-1:0]       o_waddr,
    output logic      [dtrq_pkg::HANDLE_W-1:0]    o_wdata,
    output logic      [dtrq_pkg::IDX_W-1:0]       o_raddr,
    input  wire logic [dtrq_pkg::HANDLE_W-1:0]    i_rdata,
    // result stage
    input  wire logic                             i_out_ready,
    output logic                                  o_push,
    output dtrq_pkg::t_result                     o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH_RD,
        S_FLUSH_EMIT,
        S_APPEND,
        S_QUEUED_EMIT,
        S_START_EMIT,
        S_DONE_RD,
        S_DONE_EMIT,
        S_NEXT_RD,
        S_NEXT_EMIT,
        S_REPLY
    } t_state;

    t_state                          r_state;
    logic [dtrq_pkg::HANDLE_W-1:0]   r_handle;
    logic [dtrq_pkg::IDX_W-1:0]      r_head;
    logic [dtrq_pkg::IDX_W-1:0]      r_tail;
    logic [dtrq_pkg::CNT_W-1:0]      r_count;
    logic                            r_engine;
    logic [dtrq_pkg::IDX_W-1:0]      r_ptr;
    logic [dtrq_pkg::CNT_W-1:0]      r_left;
    logic                            r_pend;
    logic                            r_first;
    dtrq_pkg::t_result               r_rep;

    logic accept;
    logic match;
    logic full;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_valid && (r_state == S_IDLE);
    assign match  = r_pend && (i_rdata == r_handle);
    assign full   = (r_count == dtrq_pkg::CNT_W'(dtrq_pkg::QUEUE_SLOTS - 1));

    // Slot RAM access: scan walks its own pointer, everything else reads head
    assign o_raddr = (r_state == S_SCAN) ? r_ptr : r_head;
    assign o_we    = (r_state == S_APPEND);
    assign o_waddr = r_tail;
    assign o_wdata = r_handle;

    // Select the result offered in each emitting state
    always_comb begin
        o_push = 1'b0;
        o_res  = r_rep;
        case (r_state)
            S_FLUSH_EMIT: begin
                o_push = i_out_ready;
                o_res  = '{handle: i_rdata, status: dtrq_pkg::ST_STOPPED,
                           reply: dtrq_pkg::RC_NONE, active: 1'b1, last: 1'b0};
            end
            S_QUEUED_EMIT: begin
                o_push = i_out_ready;
                o_res  = '{handle: r_handle, status: dtrq_pkg::ST_QUEUED,
                           reply: r_first ? dtrq_pkg::RC_NONE : dtrq_pkg::RC_QUEUED,
                           active: r_first ? 1'b1 : r_engine, last: !r_first};
            end
            S_START_EMIT: begin
                o_push = i_out_ready;
                o_res  = '{handle: r_handle, status: dtrq_pkg::ST_STARTED,
                           reply: dtrq_pkg::RC_QUEUED, active: 1'b1, last: 1'b1};
            end
            S_DONE_EMIT: begin
                o_push = i_out_ready;
                o_res  = '{handle: i_rdata, status: dtrq_pkg::ST_FINISHED,
                           reply: dtrq_pkg::RC_NONE,
                           active: (r_count > dtrq_pkg::CNT_W'(1)),
                           last: (r_count == dtrq_pkg::CNT_W'(1))};
            end
            S_NEXT_EMIT: begin
                o_push = i_out_ready;
                o_res  = '{handle: i_rdata, status: dtrq_pkg::ST_STARTED,
                           reply: dtrq_pkg::RC_NONE, active: 1'b1, last: 1'b1};
            end
            S_REPLY: begin
                o_push = i_out_ready;
                o_res  = r_rep;
            end
            default: begin
                o_push = 1'b0;
                o_res  = r_rep;
            end
        endcase
    end

    // Sequence each request through the slot RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_engine <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_handle <= i_handle;
                        case (dtrq_pkg::t_mode'(i_mode))
                            dtrq_pkg::MODE_APPEND: begin
                                r_ptr   <= r_head;
                                r_left  <= r_count;
                                r_pend  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            dtrq_pkg::MODE_REPLACE: begin
                                r_engine <= 1'b0;
                                r_state  <= (r_count == '0) ? S_APPEND : S_FLUSH_RD;
                            end
                            dtrq_pkg::MODE_DONE: begin
                                if (r_count == '0) begin
                                    r_engine <= 1'b0;
                                    r_rep    <= '{handle: '0, status: dtrq_pkg::ST_NONE,
                                                  reply: dtrq_pkg::RC_NONE, active: 1'b0,
                                                  last: 1'b1};
                                    r_state  <= S_REPLY;
                                end else begin
                                    r_state  <= S_DONE_RD;
                                end
                            end
                            default: begin
                                // unused request kind: report nothing
                                r_rep   <= '{handle: '0, status: dtrq_pkg::ST_NONE,
                                             reply: dtrq_pkg::RC_NONE, active: r_engine,
                                             last: 1'b1};
                                r_state <= S_REPLY;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // one read issued and one compared per cycle
                    if (match) begin
                        r_rep   <= '{handle: r_handle, status: dtrq_pkg::ST_NONE,
                                     reply: dtrq_pkg::RC_DUP, active: r_engine, last: 1'b1};
                        r_state <= S_REPLY;
                    end else if (!r_pend && (r_left == '0)) begin
                        if (full) begin
                            r_rep   <= '{handle: r_handle, status: dtrq_pkg::ST_NONE,
                                         reply: dtrq_pkg::RC_FULL, active: r_engine,
                                         last: 1'b1};
                            r_state <= S_REPLY;
                        end else begin
                            r_state <= S_APPEND;
                        end
                    end else begin
                        r_pend <= (r_left != '0);
                        if (r_left != '0) begin
                            r_ptr  <= dtrq_pkg::next_idx(r_ptr);
                            r_left <= r_left - dtrq_pkg::CNT_W'(1);
                        end
                    end
                end
                S_FLUSH_RD: begin
                    r_state <= S_FLUSH_EMIT;
                end
                S_FLUSH_EMIT: begin
                    // retire head as stopped
                    if (i_out_ready) begin
                        r_head  <= dtrq_pkg::next_idx(r_head);
                        r_count <= r_count - dtrq_pkg::CNT_W'(1);
                        r_state <= (r_count == dtrq_pkg::CNT_W'(1)) ? S_APPEND : S_FLUSH_RD;
                    end
                end
                S_APPEND: begin
                    r_first <= (r_count == '0);
                    r_tail  <= dtrq_pkg::next_idx(r_tail);
                    r_count <= r_count + dtrq_pkg::CNT_W'(1);
                    r_state <= S_QUEUED_EMIT;
                end
                S_QUEUED_EMIT: begin
                    if (i_out_ready) begin
                        r_state <= r_first ? S_START_EMIT : S_IDLE;
                    end
                end
                S_START_EMIT: begin
                    if (i_out_ready) begin
                        r_engine <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_DONE_RD: begin
                    r_state <= S_DONE_EMIT;
                end
                S_DONE_EMIT: begin
                    // retire head as finished, then start the next one if any
                    if (i_out_ready) begin
                        r_head   <= dtrq_pkg::next_idx(r_head);
                        r_count  <= r_count - dtrq_pkg::CNT_W'(1);
                        r_engine <= (r_count > dtrq_pkg::CNT_W'(1));
                        r_state  <= (r_count > dtrq_pkg::CNT_W'(1)) ? S_NEXT_RD : S_IDLE;
                    end
                end
                S_NEXT_RD: begin
                    r_state <= S_NEXT_EMIT;
                end
                S_NEXT_EMIT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_REPLY: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/dtrq_chk.sv =====
// ============================================================================
// dtrq_chk
// Port-level checks on the request queue, bound to the top level.
// ============================================================================
`default_nettype none

module dtrq_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_stall,
    input wire logic        o_valid,
    input wire logic [15:0] o_report_handle,
    input wire logic [2:0]  o_report_status,
    input wire logic [1:0]  o_reply_code,
    input wire logic        o_transfer_active,
    input wire logic        o_last
);

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_report_handle) && $stable(o_report_status)
                               && $stable(o_reply_code) && $stable(o_last))
        else $error("stalled result changed");

    // A refused or empty report always ends its request
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_report_status == 3'(dtrq_pkg::ST_NONE)) |-> o_last)
        else $error("no-status result not final");

    // Flushed handles precede the append, which always restarts the engine
    a_stop_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_report_status == 3'(dtrq_pkg::ST_STOPPED))
            |-> !o_last && o_transfer_active)
        else $error("stopped result out of place");

    // A started handle means the engine runs
    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_report_status == 3'(dtrq_pkg::ST_STARTED)) |-> o_transfer_active)
        else $error("started result with engine idle");

endmodule

bind dedup_transfer_request_queue_core dtrq_chk u_dtrq_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_stall           (i_stall),
    .o_valid           (o_valid),
    .o_report_handle   (o_report_handle),
    .o_report_status   (o_report_status),
    .o_reply_code      (o_reply_code),
    .o_transfer_active (o_transfer_active),
    .o_last            (o_last)
);

`default_nettype wire

// ===== tb/tb_dedup_transfer_request_queue_core.sv =====
// ============================================================================
// tb_dedup_transfer_request_queue_core
// Self-checking bench for the deduplicating transfer request queue.
// ============================================================================
// A scoreboard class keeps its own copy of the ring, the head and tail
// positions and the engine state. For every accepted request it works out the
// status reports that the block should return. Every accepted result is then
// compared field by field with the oldest outstanding report. A directed
// opening covers the corner cases: completion on an empty queue, an unknown
// mode, a duplicate, a full queue and a flush of a full ring. Random traffic
// follows. It uses a small handle pool so that duplicates stay common, and
// fill and drain phases so that the ring wraps and often runs full. Both sides
// insert random gaps. The receiver also holds off once for a long stretch,
// and the sender pauses now and then until every report has come back.
import dtrq_pkg::*;

class report_tracker;
    localparam int MAX_LOGGED = 200;

    t_result             expected_reports[$];
    t_result             step_reports[$];
    logic [HANDLE_W-1:0] slot_copy[QUEUE_SLOTS];
    int                  head_pos;
    int                  tail_pos;
    bit                  engine_on;
    int                  errors;
    int                  reports_checked;
    int                  refused_full;
    int                  refused_dup;
    int                  deepest;
    int                  mode_count[4];

    function new();
        head_pos        = 0;
        tail_pos        = 0;
        engine_on       = 1'b0;
        errors          = 0;
        reports_checked = 0;
        refused_full    = 0;
        refused_dup     = 0;
        deepest         = 0;
        foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    function int depth();
        return (tail_pos + QUEUE_SLOTS - head_pos) % QUEUE_SLOTS;
    endfunction

    function int ring_next(int pos);
        return (pos + 1) % QUEUE_SLOTS;
    endfunction

    function int outstanding();
        return expected_reports.size();
    endfunction

    function void add_report(logic [HANDLE_W-1:0] handle, t_status status, t_reply reply);
        t_result r;
        r.handle = handle;
        r.status = status;
        r.reply  = reply;
        r.active = 1'b0;
        r.last   = 1'b0;
        step_reports.push_back(r);
    endfunction

    // Scan from the head for a duplicate, then refuse or enqueue
    function void try_append(logic [HANDLE_W-1:0] handle);
        int n;
        int pos;
        bit dup;
        n   = depth();
        pos = head_pos;
        dup = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (slot_copy[pos] == handle) dup = 1'b1;
            pos = ring_next(pos);
        end
        if (dup) begin
            add_report(handle, ST_NONE, RC_DUP);
            refused_dup++;
        end else if (n >= QUEUE_SLOTS - 1) begin
            add_report(handle, ST_NONE, RC_FULL);
            refused_full++;
        end else begin
            slot_copy[tail_pos] = handle;
            tail_pos = ring_next(tail_pos);
            if (n == 0) begin
                add_report(handle, ST_QUEUED, RC_NONE);
                engine_on = 1'b1;
                add_report(handle, ST_STARTED, RC_QUEUED);
            end else begin
                add_report(handle, ST_QUEUED, RC_QUEUED);
            end
        end
    endfunction

    // Predict the reports of one accepted request and queue them
    function void note_request(logic [1:0] mode, logic [HANDLE_W-1:0] handle);
        t_result r;
        step_reports.delete();
        mode_count[mode]++;
        case (mode)
            MODE_APPEND: begin
                try_append(handle);
            end
            MODE_REPLACE: begin
                engine_on = 1'b0;
                while (depth() > 0) begin
                    add_report(slot_copy[head_pos], ST_STOPPED, RC_NONE);
                    head_pos = ring_next(head_pos);
                end
                try_append(handle);
            end
            MODE_DONE: begin
                if (depth() == 0) begin
                    engine_on = 1'b0;
                    add_report('0, ST_NONE, RC_NONE);
                end else begin
                    add_report(slot_copy[head_pos], ST_FINISHED, RC_NONE);
                    head_pos = ring_next(head_pos);
                    if (depth() > 0) begin
                        engine_on = 1'b1;
                        add_report(slot_copy[head_pos], ST_STARTED, RC_NONE);
                    end else begin
                        engine_on = 1'b0;
                    end
                end
            end
            default: begin
                add_report('0, ST_NONE, RC_NONE);
            end
        endcase
        // Engine state is the one after the whole step; flag the final report
        foreach (step_reports[i]) begin
            r        = step_reports[i];
            r.active = engine_on;
            r.last   = (i == step_reports.size() - 1);
            expected_reports.push_back(r);
        end
        if (depth() > deepest) deepest = depth();
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= MAX_LOGGED) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
        end
    endfunction

    // Compare one accepted result with the oldest outstanding report
    function void check_report(t_result got);
        t_result want;
        reports_checked++;
        if (expected_reports.size() == 0) begin
            errors++;
            if (errors <= MAX_LOGGED) begin
                $error("report with none outstanding: handle %0d, status %0d",
                       got.handle, got.status);
            end
            return;
        end
        want = expected_reports.pop_front();
        if (got.handle !== want.handle) flag("report_handle", want.handle, got.handle);
        if (got.status !== want.status) flag("report_status", want.status, got.status);
        if (got.reply !== want.reply) flag("reply_code", want.reply, got.reply);
        if (got.active !== want.active) flag("transfer_active", want.active, got.active);
        if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
endclass

module tb_dedup_transfer_request_queue_core;

    localparam logic [1:0] MODE_UNKNOWN     = 2'd3;
    localparam int         RANDOM_REQUESTS  = 455;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam int         POOL_SIZE        = 20;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_mode;
    logic [15:0]         i_handle;
    logic                o_valid;
    logic                i_stall;
    logic [15:0]         o_report_handle;
    logic [2:0]          o_report_status;
    logic [1:0]          o_reply_code;
    logic                o_transfer_active;
    logic                o_last;

    report_tracker       tracker;
    bit                  hold_off_request;
    logic [HANDLE_W-1:0] handle_pool[POOL_SIZE];

    dedup_transfer_request_queue_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_handle          (i_handle),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_report_handle   (o_report_handle),
        .o_report_status   (o_report_status),
        .o_reply_code      (o_reply_code),
        .o_transfer_active (o_transfer_active),
        .o_last            (o_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Favour the pool so that duplicates turn up often
    function automatic logic [15:0] pick_handle();
        if ($urandom_range(0, 99) < 70) return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offer one request after a gap and hold it until accepted
    task automatic send_request(input logic [1:0] mode, input logic [15:0] handle,
                                input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid  = 1'b0;
            i_mode   = 2'($urandom);
            i_handle = 16'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_mode   = mode;
        i_handle = handle;
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(mode, handle);
    endtask

    // Drop valid and wait until every outstanding report has come back
    task automatic wait_for_all_reports();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_valid && !i_stall) begin
            seen.handle = o_report_handle;
            seen.status = t_status'(o_report_status);
            seen.reply  = t_reply'(o_reply_code);
            seen.active = o_transfer_active;
            seen.last   = o_last;
            tracker.check_report(seen);
        end
    end

    // Result side: random stall runs, plus one long hold-off on request
    initial begin : result_side
        int r;
        int n;
        int held;
        wait (i_rst_n);
        forever begin
            if (hold_off_request) begin
                i_stall = 1'b1;
                held    = 0;
                while (held < LONG_HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_off_request = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                i_stall = 1'b0;
                n = $urandom_range(1, 30);
            end else if (r < 90) begin
                i_stall = 1'b1;
                n = $urandom_range(1, 3);
            end else begin
                i_stall = 1'b1;
                n = $urandom_range(8, 30);
            end
            repeat (n) @(negedge i_clk);
        end
    end

    // Request side and end of run
    initial begin : request_side
        int         r;
        int         profile;
        bit         burst;
        logic [1:0] mode;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_mode           = MODE_APPEND;
        i_handle         = '0;
        i_stall          = 1'b0;
        hold_off_request = 1'b0;
        profile          = 0;
        burst            = 1'b0;
        tracker          = new();
        foreach (handle_pool[i]) handle_pool[i] = 16'($urandom);
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Completion on an empty queue, then an unknown mode
        send_request(MODE_DONE, 16'h1111, pick_gap());
        send_request(MODE_UNKNOWN, 16'hFFFF, pick_gap());
        // Append to empty, plain append, duplicate
        send_request(MODE_APPEND, 16'hFFFF, pick_gap());
        send_request(MODE_APPEND, 16'h0000, pick_gap());
        send_request(MODE_APPEND, 16'hFFFF, pick_gap());
        // Completion that starts the next entry, then one that empties the queue
        send_request(MODE_DONE, 16'h0000, pick_gap());
        send_request(MODE_DONE, 16'hFFFF, pick_gap());
        // Replace on an empty queue, then fill the ring
        send_request(MODE_REPLACE, 16'hA5A5, pick_gap());
        for (int i = 0; i < QUEUE_SLOTS - 2; i++) begin
            send_request(MODE_APPEND, 16'(16'h0001 << i), pick_gap());
        end
        // Refused as full; duplicate of the last entry takes priority over full
        send_request(MODE_APPEND, 16'h1234, pick_gap());
        send_request(MODE_APPEND, 16'(16'h0001 << (QUEUE_SLOTS - 3)), pick_gap());
        // Flush a full ring, then retire the only entry
        send_request(MODE_REPLACE, 16'h4000, pick_gap());
        send_request(MODE_DONE, 16'h8000, pick_gap());
        wait_for_all_reports();

        // Random traffic in phases: fill, drain or mixed
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k % 40 == 0) begin
                profile = $urandom_range(0, 2);
                burst   = ($urandom_range(0, 3) == 0);
            end
            if (k == 120) hold_off_request = 1'b1;
            if (k == 240) wait_for_all_reports();
            r = $urandom_range(0, 99);
            case (profile)
                0:       mode = (r < 78) ? MODE_APPEND : (r < 83) ? MODE_REPLACE :
                                (r < 97) ? MODE_DONE : MODE_UNKNOWN;
                1:       mode = (r < 35) ? MODE_APPEND : (r < 40) ? MODE_REPLACE :
                                (r < 97) ? MODE_DONE : MODE_UNKNOWN;
                default: mode = (r < 55) ? MODE_APPEND : (r < 63) ? MODE_REPLACE :
                                (r < 97) ? MODE_DONE : MODE_UNKNOWN;
            endcase
            send_request(mode, pick_handle(), burst ? 0 : pick_gap());
        end

        // Drain, let the block settle, then report
        wait_for_all_reports();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d appends, %0d replaces, %0d completions, %0d unknown modes",
                 tracker.mode_count[MODE_APPEND], tracker.mode_count[MODE_REPLACE],
                 tracker.mode_count[MODE_DONE], tracker.mode_count[MODE_UNKNOWN]);
        $display("%0d reports checked, %0d full and %0d duplicate refusals, deepest queue %0d",
                 tracker.reports_checked, tracker.refused_full, tracker.refused_dup,
                 tracker.deepest);
        if (tracker.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dtrq_pkg.sv
design/dtrq_ram.sv
design/dtrq_out.sv
design/dtrq_seq.sv
design/dedup_transfer_request_queue_core.sv
design/dtrq_chk.sv
tb/tb_dedup_transfer_request_queue_core.sv
